FILE: design/pcm_pkg.sv
// Package for the perspective coordinate mapper.
// Holds coefficient register indexes and fixed widths of the datapath.
// No dependencies.
`timescale 1ns / 1ps

package pcm_pkg;

	localparam int COEF_W    = 48;
	localparam int NUM_COEF  = 8;
	localparam int CFG_IDX_W = 4;
	localparam int OUT_W     = 32;
	localparam int FRAC_W    = 16;
	localparam int Q_BITS    = OUT_W + 1;
	localparam int ONE_POS   = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_COL = 4'd0,
		REG_X_ROW = 4'd1,
		REG_X_OFF = 4'd2,
		REG_Y_COL = 4'd3,
		REG_Y_ROW = 4'd4,
		REG_Y_OFF = 4'd5,
		REG_W_COL = 4'd6,
		REG_W_ROW = 4'd7
	} reg_idx_t;

	typedef logic signed [COEF_W-1:0] coef_t;

endpackage

FILE: design/perspective_coordinate_mapper.sv
// Top level of the perspective coordinate mapper: front, queue and back.
// Depends on pcm_pkg, pcm_front, pcm_fifo, pcm_back.
//
// channel   direction  signals                               contents
// s_axis    in         tvalid/tready/tdata                   pixel_row, pixel_col
// m_axis    out        tvalid/tready/tdata/tuser             source_x, source_y; map_invalid
// cfg       in         cfg_valid/cfg_ready/cfg_index/cfg_data coefficient writes
//
// One item per cycle is accepted and delivered unless the output stalls; items pass
// front registers, queue, back input registers, 33 divider steps and output register.
// The divider pipeline (one quotient bit per stage) sets the latency.
// Reset clears valid state and loads identity coefficients; cfg_ready is always high.
// An output stall freezes the back part; the front keeps filling the 4-entry queue.
`timescale 1ns / 1ps

module perspective_coordinate_mapper import pcm_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// pixel_row, pixel_col
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// source_x, source_y
	output logic [2*OUT_W-1:0]                   m_axis_tdata,
	// map_invalid
	output logic                                 m_axis_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [CFG_IDX_W-1:0]                 cfg_index,
	input  logic [COEF_W-1:0]                    cfg_data
);

	localparam int SW = COEF_W + COORD_BITS + 3;

	logic             sum_valid, sum_ready, q_valid, q_rd;
	logic [3*SW-1:0]  sum_data, q_data;
	logic [OUT_W-1:0] sx, sy;

	assign cfg_ready = 1'b1;

	pcm_front #(.COORD_BITS(COORD_BITS), .SW(SW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.pixel_row (s_axis_tdata[COORD_BITS-1:0]),
		.pixel_col (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
		.sum_valid (sum_valid),
		.sum_ready (sum_ready),
		.sum_data  (sum_data)
	);

	pcm_fifo #(.DW(3*SW), .DEPTH(4)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (sum_valid),
		.wr_ready (sum_ready),
		.wr_data  (sum_data),
		.rd_valid (q_valid),
		.rd_en    (q_rd),
		.rd_data  (q_data)
	);

	pcm_back #(.SW(SW)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_rd        (q_rd),
		.q_data      (q_data),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.source_x    (sx),
		.source_y    (sy),
		.map_invalid (m_axis_tuser)
	);

	assign m_axis_tdata = {sy, sx};

endmodule

FILE: design/pcm_front.sv
// Front part: coefficient registers, item accept, products and sums X, Y, W.
// Depends on pcm_pkg.
`timescale 1ns / 1ps

module pcm_front import pcm_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int SW = COEF_W + COORD_BITS + 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [COEF_W-1:0]     cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] pixel_row,
	input  logic [COORD_BITS-1:0] pixel_col,
	output logic                  sum_valid,
	input  logic                  sum_ready,
	output logic [3*SW-1:0]       sum_data
);

	localparam int P_W = COEF_W + COORD_BITS + 1;

	coef_t coef_q [NUM_COEF];

	logic                  v_s1, v_s2, rdy_s1, rdy_s2;
	logic signed [P_W-1:0] pxc_s1, pxr_s1, pyc_s1, pyr_s1, pwc_s1, pwr_s1;
	coef_t                 offx_s1, offy_s1;
	logic signed [SW-1:0]  x_s2, y_s2, w_s2;
	logic signed [P_W-1:0] col_e, row_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEF; i++) coef_q[i] <= '0;
			coef_q[3'(REG_X_COL)] <= coef_t'(64'sh1_0000_0000);
			coef_q[3'(REG_Y_ROW)] <= coef_t'(64'sh1_0000_0000);
		end else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_COEF)) begin
			coef_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	assign rdy_s2   = !v_s2 || sum_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign col_e = P_W'($signed({1'b0, pixel_col}));
	assign row_e = P_W'($signed({1'b0, pixel_row}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			pxc_s1  <= P_W'(coef_q[3'(REG_X_COL)]) * col_e;
			pxr_s1  <= P_W'(coef_q[3'(REG_X_ROW)]) * row_e;
			pyc_s1  <= P_W'(coef_q[3'(REG_Y_COL)]) * col_e;
			pyr_s1  <= P_W'(coef_q[3'(REG_Y_ROW)]) * row_e;
			pwc_s1  <= P_W'(coef_q[3'(REG_W_COL)]) * col_e;
			pwr_s1  <= P_W'(coef_q[3'(REG_W_ROW)]) * row_e;
			offx_s1 <= coef_q[3'(REG_X_OFF)];
			offy_s1 <= coef_q[3'(REG_Y_OFF)];
		end
		if (rdy_s2 && v_s1) begin
			x_s2 <= SW'(pxc_s1) + SW'(pxr_s1) + SW'(offx_s1);
			y_s2 <= SW'(pyc_s1) + SW'(pyr_s1) + SW'(offy_s1);
			w_s2 <= SW'(pwc_s1) + SW'(pwr_s1) + (SW'(1) <<< ONE_POS);
		end
	end

	assign sum_valid = v_s2;
	assign sum_data  = {w_s2, y_s2, x_s2};

endmodule

FILE: design/pcm_fifo.sv
// Short queue between the front and back parts.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module pcm_fifo #(
	parameter int DW = 8,
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  logic [DW-1:0] wr_data,
	output logic          rd_valid,
	input  logic          rd_en,
	output logic [DW-1:0] rd_data
);

	localparam int AW = $clog2(DEPTH);

	logic [DW-1:0]  mem_q [DEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [AW:0]    cnt_q;
	logic           wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_en && rd_valid;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("queue count beyond depth");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		wr && !rd |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count lost a write");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> wp_q == rp_q) else $error("empty queue with split pointers");
`endif

endmodule

FILE: design/pcm_back.sv
// Back part: sign split, overflow check, restoring divider pipeline and saturation.
// Depends on pcm_pkg.
`timescale 1ns / 1ps

module pcm_back import pcm_pkg::*; #(
	parameter int SW = 63
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_rd,
	input  logic [3*SW-1:0]  q_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] source_x,
	output logic [OUT_W-1:0] source_y,
	output logic             map_invalid
);

	localparam int M = SW;
	localparam int SH = Q_BITS - FRAC_W;

	logic adv;
	logic signed [SW-1:0] xi, yi, wi;

	logic         v_s1, sx_s1, sy_s1, sw_s1, wz_s1;
	logic [M-1:0] mx_s1, my_s1, d_s1;

	logic              v_s2, ovx_s2, ovy_s2, negx_s2, negy_s2, sx_s2, sy_s2, wz_s2;
	logic [M-1:0]      rx_s2, ry_s2, d_s2;
	logic [Q_BITS-1:0] lx_s2, ly_s2;

	logic              v_q   [Q_BITS];
	logic [M-1:0]      rx_q  [Q_BITS];
	logic [M-1:0]      ry_q  [Q_BITS];
	logic [M-1:0]      d_q   [Q_BITS];
	logic [Q_BITS-1:0] lx_q  [Q_BITS];
	logic [Q_BITS-1:0] ly_q  [Q_BITS];
	logic [Q_BITS-1:0] qx_q  [Q_BITS];
	logic [Q_BITS-1:0] qy_q  [Q_BITS];
	logic [6:0]        fl_q  [Q_BITS];

	logic [M-1:0]      prx [Q_BITS];
	logic [M-1:0]      pry [Q_BITS];
	logic [M-1:0]      pd  [Q_BITS];
	logic [Q_BITS-1:0] plx [Q_BITS];
	logic [Q_BITS-1:0] ply [Q_BITS];
	logic [Q_BITS-1:0] pqx [Q_BITS];
	logic [Q_BITS-1:0] pqy [Q_BITS];
	logic              pv  [Q_BITS];
	logic [6:0]        pfl [Q_BITS];
	logic [M:0]        tx  [Q_BITS];
	logic [M:0]        ty  [Q_BITS];
	logic              gx  [Q_BITS];
	logic              gy  [Q_BITS];

	logic              out_v_q, inv_q;
	logic [OUT_W-1:0]  ox_q, oy_q;

	// flags carried with each item: ovx, ovy, negx, negy, sx, sy, wz
	logic              f_ovx, f_ovy, f_negx, f_negy, f_sx, f_sy, f_wz, badx, bady;
	logic [Q_BITS-1:0] fqx, fqy;
	logic [OUT_W-1:0]  vx, vy;

	assign adv  = !out_v_q || out_ready;
	assign q_rd = adv;
	assign xi = q_data[SW-1:0];
	assign yi = q_data[2*SW-1:SW];
	assign wi = q_data[3*SW-1:2*SW];

	always_comb begin
		for (int k = 0; k < Q_BITS; k++) begin
			if (k == 0) begin
				pv[k] = v_s2; prx[k] = rx_s2; pry[k] = ry_s2; pd[k] = d_s2;
				plx[k] = lx_s2; ply[k] = ly_s2; pqx[k] = '0; pqy[k] = '0;
				pfl[k] = {ovx_s2, ovy_s2, negx_s2, negy_s2, sx_s2, sy_s2, wz_s2};
			end else begin
				pv[k] = v_q[k-1]; prx[k] = rx_q[k-1]; pry[k] = ry_q[k-1];
				pd[k] = d_q[k-1]; plx[k] = lx_q[k-1]; ply[k] = ly_q[k-1];
				pqx[k] = qx_q[k-1]; pqy[k] = qy_q[k-1]; pfl[k] = fl_q[k-1];
			end
			tx[k] = {prx[k], plx[k][Q_BITS-1]};
			ty[k] = {pry[k], ply[k][Q_BITS-1]};
			gx[k] = tx[k] >= {1'b0, pd[k]};
			gy[k] = ty[k] >= {1'b0, pd[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
			for (int k = 0; k < Q_BITS; k++) v_q[k] <= 1'b0;
		end else if (adv) begin
			v_s1    <= q_valid;
			v_s2    <= v_s1;
			for (int k = 0; k < Q_BITS; k++) v_q[k] <= pv[k];
			out_v_q <= v_q[Q_BITS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s1 <= xi[SW-1];
			sy_s1 <= yi[SW-1];
			sw_s1 <= wi[SW-1];
			wz_s1 <= wi == '0;
			mx_s1 <= xi[SW-1] ? M'(-xi) : M'(xi);
			my_s1 <= yi[SW-1] ? M'(-yi) : M'(yi);
			d_s1  <= wi[SW-1] ? M'(-wi) : M'(wi);

			ovx_s2  <= (mx_s1 >> SH) >= d_s1;
			ovy_s2  <= (my_s1 >> SH) >= d_s1;
			rx_s2   <= ((mx_s1 >> SH) >= d_s1) ? '0 : (mx_s1 >> SH);
			ry_s2   <= ((my_s1 >> SH) >= d_s1) ? '0 : (my_s1 >> SH);
			lx_s2   <= {mx_s1[SH-1:0], {FRAC_W{1'b0}}};
			ly_s2   <= {my_s1[SH-1:0], {FRAC_W{1'b0}}};
			d_s2    <= d_s1;
			negx_s2 <= sx_s1 ^ sw_s1;
			negy_s2 <= sy_s1 ^ sw_s1;
			sx_s2   <= sx_s1;
			sy_s2   <= sy_s1;
			wz_s2   <= wz_s1;

			for (int k = 0; k < Q_BITS; k++) begin
				rx_q[k] <= gx[k] ? M'(tx[k] - {1'b0, pd[k]}) : tx[k][M-1:0];
				ry_q[k] <= gy[k] ? M'(ty[k] - {1'b0, pd[k]}) : ty[k][M-1:0];
				lx_q[k] <= plx[k] << 1;
				ly_q[k] <= ply[k] << 1;
				qx_q[k] <= {pqx[k][Q_BITS-2:0], gx[k]};
				qy_q[k] <= {pqy[k][Q_BITS-2:0], gy[k]};
				d_q[k]  <= pd[k];
				fl_q[k] <= pfl[k];
			end

			ox_q  <= vx;
			oy_q  <= vy;
			inv_q <= f_wz || badx || bady;
		end
	end

	always_comb begin
		{f_ovx, f_ovy, f_negx, f_negy, f_sx, f_sy, f_wz} = fl_q[Q_BITS-1];
		fqx = qx_q[Q_BITS-1];
		fqy = qy_q[Q_BITS-1];
		if (f_negx) badx = f_ovx || fqx > Q_BITS'(33'h0_8000_0000);
		else        badx = f_ovx || fqx[Q_BITS-1] || fqx[Q_BITS-2];
		if (f_negy) bady = f_ovy || fqy > Q_BITS'(33'h0_8000_0000);
		else        bady = f_ovy || fqy[Q_BITS-1] || fqy[Q_BITS-2];
		if (f_wz)       vx = f_sx ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else if (badx)  vx = f_negx ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else if (f_negx) vx = OUT_W'(-fqx);
		else            vx = fqx[OUT_W-1:0];
		if (f_wz)       vy = f_sy ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else if (bady)  vy = f_negy ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else if (f_negy) vy = OUT_W'(-fqy);
		else            vy = fqy[OUT_W-1:0];
	end

	assign out_valid   = out_v_q;
	assign source_x    = ox_q;
	assign source_y    = oy_q;
	assign map_invalid = inv_q;

endmodule
